// ===== sv/fsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants of the free segment coalescer
// Operation codes, merge codes, word layouts and the command/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

  // Default table depth
  localparam int SLOTS_DEF = 64;

  // Field widths
  localparam int OP_W    = 2;
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 32;
  localparam int RSLOT_W = 6;
  localparam int MC_W    = 2;

  // Input word layout (tdata), operation travels in tuser
  localparam int IN_DATA_W = 72;
  localparam int IN_USER_W = OP_W;

  // Output word layout (tdata)
  localparam int OUT_DATA_W = 80;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;

  // Merge codes
  localparam logic [MC_W-1:0] MC_NONE  = 2'd0;
  localparam logic [MC_W-1:0] MC_RIGHT = 2'd1;
  localparam logic [MC_W-1:0] MC_LEFT  = 2'd2;
  localparam logic [MC_W-1:0] MC_BOTH  = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic latch;    // capture input word, restart scan
    logic clr;      // clear valid bit at the scan counter
    logic cnt_inc;  // advance scan counter
    logic scan;     // table read at scan counter is evaluated next cycle
    logic sum1;     // first merged-length add
    logic sum2;     // second merged-length add (both neighbours)
    logic commit;   // write back table and load output register
  } fsc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_last;  // scan counter at last slot
    logic merge;     // release found at least one neighbour
    logic both;      // release found both neighbours
    logic out_free;  // output register can take a word
  } fsc_stat_t;

endpackage

`default_nettype wire

// ===== sv/fsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsc_ctrl: sequencer of the free segment coalescer
// Runs the clearing pass, the table scan, the readout and the merge and write-back steps.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  input  wire logic [fsc_pkg::OP_W-1:0]   in_op,
  output logic                            in_tready,
  input  wire fsc_pkg::fsc_stat_t         stat,
  output fsc_pkg::fsc_cmd_t               cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_DECIDE,
    ST_SUM1,
    ST_SUM2,
    ST_RD,
    ST_COMMIT
  } state_t;

  state_t state_r;
  logic   rdy_r;
  logic   accept;

  assign in_tready = rdy_r;
  assign accept    = in_tvalid && rdy_r;

  // Command decode
  always_comb begin
    cmd         = '0;
    cmd.latch   = accept;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr     = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan    = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      ST_SUM1:   cmd.sum1   = 1'b1;
      ST_SUM2:   cmd.sum2   = 1'b1;
      ST_COMMIT: cmd.commit = stat.out_free;
      default:   ;
    endcase
  end

  // State and ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      rdy_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          if (stat.cnt_last) begin
            state_r <= ST_IDLE;
            rdy_r   <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            rdy_r <= 1'b0;
            if (in_op == fsc_pkg::OP_LOAD || in_op == fsc_pkg::OP_RELEASE) begin
              state_r <= ST_SCAN;
            end else if (in_op == fsc_pkg::OP_READ) begin
              state_r <= ST_RD;
            end else begin
              state_r <= ST_COMMIT;
            end
          end
        end
        ST_SCAN: begin
          if (stat.cnt_last) begin
            state_r <= ST_TAIL;
          end
        end
        ST_TAIL:   state_r <= ST_DECIDE;
        ST_DECIDE: state_r <= stat.merge ? ST_SUM1 : ST_COMMIT;
        ST_SUM1:   state_r <= stat.both ? ST_SUM2 : ST_COMMIT;
        ST_SUM2:   state_r <= ST_COMMIT;
        ST_RD:     state_r <= ST_COMMIT;
        ST_COMMIT: begin
          if (stat.out_free) begin
            state_r <= ST_IDLE;
            rdy_r   <= 1'b1;
          end
        end
        default: begin
          state_r <= ST_CLEAR;
          rdy_r   <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/fsc_datapath.sv =====
// ----------------------------------------------------------------------------
// fsc_datapath: segment table and merge arithmetic
// Holds the table memories, the scan counter, the neighbour search registers
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_datapath #(
  parameter int SLOTS = fsc_pkg::SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fsc_pkg::fsc_cmd_t             cmd,
  output fsc_pkg::fsc_stat_t                 stat,
  // input fields
  input  wire logic [fsc_pkg::OP_W-1:0]      in_op,
  input  wire logic [fsc_pkg::ADDR_W-1:0]    in_start,
  input  wire logic [fsc_pkg::LEN_W-1:0]     in_len,
  input  wire logic [fsc_pkg::RSLOT_W-1:0]   in_rslot,
  // output register
  input  wire logic                          out_tready,
  output logic                               out_tvalid,
  output logic [fsc_pkg::ADDR_W-1:0]         out_start,
  output logic [fsc_pkg::LEN_W-1:0]          out_len,
  output logic                               out_seg_valid,
  output logic [fsc_pkg::RSLOT_W-1:0]        out_slot,
  output logic [fsc_pkg::MC_W-1:0]           out_mc,
  output logic                               out_ovf
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);
  localparam logic [fsc_pkg::RSLOT_W:0] RS_LIM =
    (fsc_pkg::RSLOT_W + 1)'((SLOTS >= 64) ? 64 : SLOTS);

  // Table memories
  logic [fsc_pkg::ADDR_W-1:0] mem_start [SLOTS];
  logic [fsc_pkg::LEN_W-1:0]  mem_len   [SLOTS];
  logic                       mem_valid [SLOTS];

  // Captured input word
  logic [fsc_pkg::OP_W-1:0]    op_r;
  logic [fsc_pkg::ADDR_W-1:0]  s_r;
  logic [fsc_pkg::LEN_W-1:0]   l_r;
  logic [fsc_pkg::RSLOT_W-1:0] rs_r;
  logic [fsc_pkg::ADDR_W-1:0]  end_r;

  // Scan and registered read data
  logic [AW-1:0]              cnt_r;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              rd_idx_r;
  logic                       rd_live_r;
  logic [fsc_pkg::ADDR_W-1:0] rd_start_r;
  logic [fsc_pkg::LEN_W-1:0]  rd_len_r;
  logic                       rd_valid_r;
  logic [fsc_pkg::ADDR_W-1:0] rd_end;
  logic                       hit_left;
  logic                       hit_right;
  logic                       hit_empty;

  // Search results
  logic                       left_f_r;
  logic [AW-1:0]              left_idx_r;
  logic [fsc_pkg::ADDR_W-1:0] left_start_r;
  logic [fsc_pkg::LEN_W-1:0]  left_len_r;
  logic                       right_f_r;
  logic [AW-1:0]              right_idx_r;
  logic [fsc_pkg::LEN_W-1:0]  right_len_r;
  logic                       empty_f_r;
  logic [AW-1:0]              empty_idx_r;
  logic                       right_eff;
  logic                       is_rel;
  logic [fsc_pkg::LEN_W-1:0]  sum_r;

  // Commit results
  logic                       d_we;
  logic                       s_we;
  logic [AW-1:0]              d_addr;
  logic                       v_we;
  logic [AW-1:0]              v_addr;
  logic                       v_data;
  logic [fsc_pkg::ADDR_W-1:0] res_start;
  logic [fsc_pkg::LEN_W-1:0]  res_len;
  logic                       res_valid;
  logic [fsc_pkg::RSLOT_W-1:0] res_slot;
  logic [fsc_pkg::MC_W-1:0]   res_mc;
  logic                       res_ovf;
  logic                       rs_in_range;

  // Capture input word
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_op;
      s_r   <= in_start;
      l_r   <= in_len;
      rs_r  <= in_rslot;
      end_r <= in_start + in_len;
    end
  end

  // Scan counter
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.latch) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= (cnt_r == LAST) ? '0 : cnt_r + AW'(1);
    end
  end

  // Table read, one address a cycle
  assign rd_addr = (op_r == fsc_pkg::OP_READ) ? AW'(rs_r) : cnt_r;

  always_ff @(posedge clk) begin
    rd_start_r <= mem_start[rd_addr];
    rd_len_r   <= mem_len[rd_addr];
    rd_valid_r <= mem_valid[rd_addr];
    rd_idx_r   <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_live_r <= 1'b0;
    end else begin
      rd_live_r <= cmd.scan;
    end
  end

  // Neighbour and empty-slot match on the word just read
  assign rd_end    = rd_start_r + rd_len_r;
  assign hit_left  = rd_live_r && rd_valid_r && (rd_end == s_r);
  assign hit_right = rd_live_r && rd_valid_r && (rd_start_r == end_r);
  assign hit_empty = rd_live_r && !rd_valid_r;

  // Keep the lowest matching slot of each kind
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.latch) begin
      left_f_r  <= 1'b0;
      right_f_r <= 1'b0;
      empty_f_r <= 1'b0;
    end else begin
      if (hit_left && !left_f_r) begin
        left_f_r <= 1'b1;
      end
      if (hit_right && !right_f_r) begin
        right_f_r <= 1'b1;
      end
      if (hit_empty && !empty_f_r) begin
        empty_f_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit_left && !left_f_r) begin
      left_idx_r   <= rd_idx_r;
      left_start_r <= rd_start_r;
      left_len_r   <= rd_len_r;
    end
    if (hit_right && !right_f_r) begin
      right_idx_r <= rd_idx_r;
      right_len_r <= rd_len_r;
    end
    if (hit_empty && !empty_f_r) begin
      empty_idx_r <= rd_idx_r;
    end
  end

  // A slot matching both sides counts as left neighbour only
  assign right_eff = right_f_r && !(left_f_r && (right_idx_r == left_idx_r));
  assign is_rel    = (op_r == fsc_pkg::OP_RELEASE);

  // Merged length, one add per step
  always_ff @(posedge clk) begin
    if (cmd.sum1) begin
      sum_r <= (left_f_r ? left_len_r : right_len_r) + l_r;
    end else if (cmd.sum2) begin
      sum_r <= sum_r + right_len_r;
    end
  end

  assign rs_in_range = ({1'b0, rs_r} < RS_LIM);

  // Write-back and result selection
  always_comb begin
    d_we      = 1'b0;
    s_we      = 1'b0;
    d_addr    = empty_idx_r;
    v_we      = cmd.clr;
    v_addr    = cnt_r;
    v_data    = 1'b0;
    res_start = '0;
    res_len   = '0;
    res_valid = 1'b0;
    res_slot  = '0;
    res_mc    = fsc_pkg::MC_NONE;
    res_ovf   = 1'b0;
    case (op_r)
      fsc_pkg::OP_LOAD, fsc_pkg::OP_RELEASE: begin
        if (is_rel && left_f_r) begin
          // grow the left neighbour, drop the right one if also merged
          d_we      = cmd.commit;
          d_addr    = left_idx_r;
          v_we      = cmd.commit && right_eff;
          v_addr    = right_idx_r;
          res_start = left_start_r;
          res_len   = sum_r;
          res_valid = 1'b1;
          res_slot  = fsc_pkg::RSLOT_W'(left_idx_r);
          res_mc    = right_eff ? fsc_pkg::MC_BOTH : fsc_pkg::MC_LEFT;
        end else if (is_rel && right_eff) begin
          // right neighbour takes the released start
          d_we      = cmd.commit;
          s_we      = cmd.commit;
          d_addr    = right_idx_r;
          res_start = s_r;
          res_len   = sum_r;
          res_valid = 1'b1;
          res_slot  = fsc_pkg::RSLOT_W'(right_idx_r);
          res_mc    = fsc_pkg::MC_RIGHT;
        end else begin
          // new segment in the lowest empty slot
          res_start = s_r;
          res_len   = l_r;
          if (empty_f_r) begin
            d_we      = cmd.commit;
            s_we      = cmd.commit;
            d_addr    = empty_idx_r;
            v_we      = cmd.commit;
            v_addr    = empty_idx_r;
            v_data    = 1'b1;
            res_valid = 1'b1;
            res_slot  = fsc_pkg::RSLOT_W'(empty_idx_r);
          end else begin
            res_ovf = 1'b1;
          end
        end
      end
      fsc_pkg::OP_READ: begin
        res_slot = rs_r;
        if (rs_in_range && rd_valid_r) begin
          res_start = rd_start_r;
          res_len   = rd_len_r;
          res_valid = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Table writes
  always_ff @(posedge clk) begin
    if (d_we) begin
      mem_len[d_addr] <= (s_we && !(is_rel && (left_f_r || right_eff))) ? l_r : sum_r;
    end
    if (s_we) begin
      mem_start[d_addr] <= s_r;
    end
    if (v_we) begin
      mem_valid[v_addr] <= v_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_start     <= res_start;
      out_len       <= res_len;
      out_seg_valid <= res_valid;
      out_slot      <= res_slot;
      out_mc        <= res_mc;
      out_ovf       <= res_ovf;
    end
  end

  // Status
  assign stat.cnt_last = (cnt_r == LAST);
  assign stat.merge    = is_rel && (left_f_r || right_eff);
  assign stat.both     = is_rel && left_f_r && right_eff;
  assign stat.out_free = !out_tvalid || out_tready;

endmodule

`default_nettype wire

// ===== sv/free_segment_coalescer.sv =====
// ----------------------------------------------------------------------------
// free_segment_coalescer: free segment table with boundary coalescing
// Loads, releases (merging with free neighbours) and reads out segments.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake          | Payload
//  --------+-----+--------------------+---------------------------------------
//  in_     | in  | in_tvalid/tready   | tuser: operation; tdata: start, length,
//          |     |                    | read_slot
//  out_    | out | out_tvalid/tready  | tdata: seg_start, seg_length,
//          |     |                    | seg_valid, slot_used, merge_case, ovf
//
//  Load and release scan every table slot, one slot per cycle through the
//  table read port, then a tail and a decide step, a sum step for a merge
//  and a second for a two-side merge, then commit. Readout has a read step
//  before commit; an unused code goes straight to commit. After reset a
//  clearing pass over every slot empties the table; in_tready stays low
//  until it ends. A stalled output word holds the next result in the commit
//  step; the next input word is taken while a result waits.
`default_nettype none

module free_segment_coalescer #(
  parameter int SLOTS = fsc_pkg::SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input words
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [fsc_pkg::IN_DATA_W-1:0]    in_tdata,  // base_addr, length, read_slot, pad
  input  wire logic [fsc_pkg::IN_USER_W-1:0]    in_tuser,  // operation
  // result words
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [fsc_pkg::OUT_DATA_W-1:0]        out_tdata  // seg_start, seg_length, seg_valid,
                                                           // slot_used, merge_case, overflow, pad
);

  fsc_pkg::fsc_cmd_t           cmd;
  fsc_pkg::fsc_stat_t          stat;
  logic [fsc_pkg::ADDR_W-1:0]  seg_start;
  logic [fsc_pkg::LEN_W-1:0]   seg_length;
  logic                        seg_valid;
  logic [fsc_pkg::RSLOT_W-1:0] slot_used;
  logic [fsc_pkg::MC_W-1:0]    merge_case;
  logic                        overflow;

  fsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fsc_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_op         (in_tuser),
    .in_start      (in_tdata[31:0]),
    .in_len        (in_tdata[63:32]),
    .in_rslot      (in_tdata[69:64]),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_start     (seg_start),
    .out_len       (seg_length),
    .out_seg_valid (seg_valid),
    .out_slot      (slot_used),
    .out_mc        (merge_case),
    .out_ovf       (overflow)
  );

  // Pack result word, lowest field first
  assign out_tdata = {6'd0, overflow, merge_case, slot_used, seg_valid, seg_length, seg_start};

endmodule

`default_nettype wire
